### design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### design/atan_ts_pkg.sv
// Shared types, constants and tangent table for the atan2 table search block
package atan_ts_pkg;

	localparam int IN_W    = 32;
	localparam int ANGLE_W = 25;
	localparam int NUM_W   = 49;
	localparam int DEN_W   = 33;
	localparam int QUOT_W  = 31;
	localparam int ADDR_W  = 8;
	localparam int BOUND_W = 10;

	localparam logic [14:0] QUOT_LIMIT = 15'd32767;
	localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 25'sd4194304;
	localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 25'sd8388608;

	typedef struct packed {
		logic              rd;
		logic [ADDR_W-1:0] addr;
	} rom_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_stat_t;

	localparam logic signed [31:0] TAN_ROM [256] = '{
		0, 804, 1609, 2414, 3220, 4026, 4834, 5644,
		6455, 7268, 8083, 8901, 9721, 10545, 11372, 12202,
		13036, 13874, 14717, 15564, 16416, 17273, 18136, 19005,
		19880, 20762, 21650, 22546, 23449, 24360, 25280, 26208,
		27146, 28093, 29050, 30018, 30996, 31986, 32988, 34002,
		35030, 36071, 37126, 38196, 39281, 40382, 41500, 42636,
		43790, 44963, 46156, 47369, 48605, 49863, 51145, 52451,
		53784, 55144, 56532, 57950, 59398, 60880, 62395, 63947,
		65536, 67165, 68835, 70548, 72308, 74116, 75974, 77887,
		79856, 81885, 83977, 86135, 88365, 90670, 93054, 95523,
		98082, 100736, 103493, 106358, 109340, 112447, 115687, 119071,
		122609, 126314, 130198, 134276, 138564, 143081, 147847, 152884,
		158218, 163878, 169896, 176309, 183161, 190499, 198380, 206870,
		216043, 225990, 236817, 248648, 261634, 275959, 291845, 309568,
		329472, 351993, 377693, 407305, 441808, 482534, 531352, 590958,
		665398, 761030, 888450, 1066730, 1334016, 1779314, 2669641, 5340086,
		-2147483647, -5340086, -2669641, -1779314, -1334016, -1066730, -888450, -761030,
		-665398, -590958, -531352, -482534, -441808, -407305, -377693, -351993,
		-329472, -309568, -291845, -275959, -261634, -248648, -236817, -225990,
		-216043, -206870, -198380, -190499, -183161, -176309, -169896, -163878,
		-158218, -152884, -147847, -143081, -138564, -134276, -130198, -126314,
		-122609, -119071, -115687, -112447, -109340, -106358, -103493, -100736,
		-98082, -95523, -93054, -90670, -88365, -86135, -83977, -81885,
		-79856, -77887, -75974, -74116, -72308, -70548, -68835, -67165,
		-65536, -63947, -62395, -60880, -59398, -57950, -56532, -55144,
		-53784, -52451, -51145, -49863, -48605, -47369, -46156, -44963,
		-43790, -42636, -41500, -40382, -39281, -38196, -37126, -36071,
		-35030, -34002, -32988, -31986, -30996, -30018, -29050, -28093,
		-27146, -26208, -25280, -24360, -23449, -22546, -21650, -20762,
		-19880, -19005, -18136, -17273, -16416, -15564, -14717, -13874,
		-13036, -12202, -11372, -10545, -9721, -8901, -8083, -7268,
		-6455, -5644, -4834, -4026, -3220, -2414, -1609, -804
	};

endpackage

### design/fixed_point_atan2_table_search.sv
// Four-quadrant fixed-point arctangent by division and tangent table search
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: y_value, x_value
//  m_*       out  m_tvalid/m_tready  m_tdata: angle; m_tuser: domain_error
//
// One item at a time. A zero x or an oversized quotient goes from accept through
// the multiply and check states straight to finish. Others also run the
// bit-serial divider (one quotient bit per cycle), then up to 8 table probes
// (a registered ROM read, then a compare), and then finish.
// The result sits in an output register, so a new item is taken while it waits.
// Reset clears the control state and the output valid; no clearing pass.
module fixed_point_atan2_table_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] y_value, [63:32] x_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [24:0] angle, [31:25] zero
	output logic [0:0]  m_tuser    // [0] domain_error
);
	import atan_ts_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_CHK   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_PROBE = 3'd4;
	localparam logic [2:0] ST_CMP   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]                 state_q;
	logic                       out_valid_q;
	logic signed [IN_W-1:0]     y_q;
	logic signed [IN_W-1:0]     x_q;
	logic [IN_W-1:0]            ay_q;
	logic [IN_W-1:0]            ax_q;
	logic [IN_W+14:0]           prod_q;
	logic signed [IN_W-1:0]     quot_q;
	logic signed [BOUND_W-1:0]  lo_q;
	logic signed [BOUND_W-1:0]  hi_q;
	logic [ADDR_W-1:0]          mid_q;
	logic signed [ANGLE_W-1:0]  ang_q;
	logic                       err_q;
	logic [ANGLE_W-1:0]         angle_out_q;
	logic                       err_out_q;

	logic                       y_neg;
	logic                       x_neg;
	logic                       over;
	logic                       div_start;
	logic [NUM_W-1:0]           dividend;
	logic [DEN_W-1:0]           divisor;
	div_stat_t                  div_stat;
	rom_req_t                   rom_req;
	logic signed [31:0]         rom_data;
	logic signed [IN_W-1:0]     quot_signed;
	logic [BOUND_W-1:0]         bound_sum;
	logic [ADDR_W-1:0]          mid;
	logic signed [BOUND_W-1:0]  lo_n;
	logic signed [BOUND_W-1:0]  hi_n;
	logic signed [ANGLE_W-1:0]  quarter;
	logic signed [ANGLE_W-1:0]  tab_ang;
	logic signed [ANGLE_W-1:0]  fin_ang;
	logic                       out_load;

	assign y_neg    = y_q[IN_W-1];
	assign x_neg    = x_q[IN_W-1];
	assign over     = {15'd0, ay_q} > prod_q;
	assign quarter  = y_neg ? -QUARTER_TURN : QUARTER_TURN;
	assign dividend = {ay_q, 17'd0} + {17'd0, ax_q};
	assign divisor  = {ax_q, 1'b0};
	assign div_start = (state_q == ST_CHK) && (x_q != '0) && !over;

	assign quot_signed = (y_neg ^ x_neg) ? -$signed({1'b0, div_stat.quot})
	                                     :  $signed({1'b0, div_stat.quot});

	assign bound_sum   = lo_q + hi_q;
	assign mid         = bound_sum[ADDR_W:1];
	assign rom_req.rd   = (state_q == ST_PROBE);
	assign rom_req.addr = mid;

	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (quot_q > rom_data) begin
			lo_n = $signed({2'b00, mid_q}) + 10'sd1;
		end else if (quot_q < rom_data) begin
			hi_n = $signed({2'b00, mid_q}) - 10'sd1;
		end
	end

	// Negative-range index read as a signed byte gives the table angle directly
	assign tab_ang = $signed({{2{mid_q[ADDR_W-1]}}, mid_q, 15'd0});
	assign fin_ang = !x_neg ? tab_ang : (y_neg ? tab_ang - HALF_TURN : tab_ang + HALF_TURN);

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_tready);

	atan_ts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.stat     (div_stat)
	);

	atan_ts_rom u_rom (
		.clk   (clk),
		.req   (rom_req),
		.rdata (rom_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_CHK;
				ST_CHK: begin
					state_q <= div_start ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: state_q <= ST_CMP;
				ST_CMP: begin
					if (lo_n <= hi_n && quot_q != rom_data) begin
						state_q <= ST_PROBE;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				y_q  <= s_tdata[31:0];
				x_q  <= s_tdata[63:32];
				ay_q <= s_tdata[31] ? 32'(-s_tdata[31:0]) : s_tdata[31:0];
				ax_q <= s_tdata[63] ? 32'(-s_tdata[63:32]) : s_tdata[63:32];
			end
			ST_MUL: prod_q <= {15'd0, ax_q} * {32'd0, QUOT_LIMIT};
			ST_CHK: begin
				err_q <= (x_q == '0) && (y_q == '0);
				if (x_q == '0 && y_q == '0) begin
					ang_q <= '0;
				end else begin
					ang_q <= quarter;
				end
			end
			ST_DIV: begin
				quot_q <= quot_signed;
				// Search the negative half of the table for a negative quotient
				if (quot_signed < 0) begin
					lo_q <= 10'sd128;
					hi_q <= 10'sd255;
				end else begin
					lo_q <= 10'sd0;
					hi_q <= 10'sd127;
				end
			end
			ST_PROBE: mid_q <= mid;
			ST_CMP: begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				ang_q <= fin_ang;
				err_q <= 1'b0;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			angle_out_q <= ang_q;
			err_out_q   <= err_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, angle_out_q};
	assign m_tuser  = err_out_q;

endmodule

### design/atan_ts_div.sv
// Radix-2 restoring divider, one quotient bit per cycle
module atan_ts_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [atan_ts_pkg::NUM_W-1:0]     dividend,
	input  logic [atan_ts_pkg::DEN_W-1:0]     divisor,
	output atan_ts_pkg::div_stat_t            stat
);
	import atan_ts_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [QUOT_W-1:0] nq_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              fits;

	assign trial = {rem_q, nq_q[QUOT_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= {{(DEN_W-(NUM_W-QUOT_W)){1'b0}}, dividend[NUM_W-1:QUOT_W]};
			nq_q  <= dividend[QUOT_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			nq_q  <= {nq_q[QUOT_W-2:0], fits};
		end
	end

	assign stat.done = done_q;
	assign stat.quot = nq_q;

endmodule

### design/atan_ts_rom.sv
// Tangent ROM with a registered read port
module atan_ts_rom (
	input  logic                  clk,
	input  atan_ts_pkg::rom_req_t req,
	output logic signed [31:0]    rdata
);
	import atan_ts_pkg::*;

	logic signed [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.rd) begin
			rdata_q <= TAN_ROM[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/atan_ts_checker.sv
// Port-level checker for the atan2 table search block, bound to the top level
`include "assert_macros.svh"

module atan_ts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// A result waits until taken
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// One item at a time: input closes right after an accept
	`ASSERT_NEXT(a_in_close, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// Domain error always comes with a zero angle
	`ASSERT_SAME(a_err_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[24:0] == 25'd0)

	// Angle stays within plus or minus a half turn, padding stays zero
	`ASSERT_SAME(a_angle_range, clk, arst_n, m_tvalid,
		(m_tdata[31:25] == 7'd0) && ((m_tdata[24] == m_tdata[23]) || (m_tdata[22:0] == 23'd0)))

endmodule

bind fixed_point_atan2_table_search atan_ts_checker u_atan_ts_checker (.*);

### tb/sv/fixed_point_atan2_table_search_tb.sv
// Self-checking testbench for the fixed-point atan2 table search block
module fixed_point_atan2_table_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import atan_ts_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1026;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               domain_error;
	} angle_result_t;

	// Predicts the binary angle of each item and holds the angles still owed
	class AngleScoreboard;
		angle_result_t owed_q[$];
		int            fails;

		function new();
			fails = 0;
		endfunction

		function longint search_table(longint quot);
			int     lo;
			int     hi;
			int     mid;
			longint diff;
			if (quot >= 0) begin
				lo = 0;
				hi = 127;
			end else begin
				lo = 128;
				hi = 255;
			end
			// stop on exact hit or when bounds cross; keep the last probe
			do begin
				mid  = (lo + hi) >> 1;
				diff = quot - longint'(TAN_ROM[mid]);
				if (diff > 0)
					lo = mid + 1;
				else if (diff < 0)
					hi = mid - 1;
			end while (lo <= hi && diff != 0);
			if (quot >= 0)
				return longint'(mid) * 32768;
			return longint'(mid) * 32768 - longint'(HALF_TURN);
		endfunction

		function angle_result_t predict_angle(logic signed [31:0] y, logic signed [31:0] x);
			angle_result_t res;
			longint        sy;
			longint        sx;
			longint        ay;
			longint        ax;
			longint        quot;
			longint        ang;
			sy = y;
			sx = x;
			res.domain_error = 1'b0;
			if (sx == 0) begin
				if (sy == 0) begin
					ang = 0;
					res.domain_error = 1'b1;
				end else begin
					ang = (sy < 0) ? -longint'(QUARTER_TURN) : longint'(QUARTER_TURN);
				end
			end else begin
				ay = (sy < 0) ? -sy : sy;
				ax = (sx < 0) ? -sx : sx;
				if (ay > longint'(QUOT_LIMIT) * ax) begin
					ang = (sy < 0) ? -longint'(QUARTER_TURN) : longint'(QUARTER_TURN);
				end else begin
					// round half away from zero
					quot = ((ay << 17) + ax) / (ax << 1);
					if ((sy < 0) != (sx < 0))
						quot = -quot;
					ang = search_table(quot);
					if (sx < 0)
						ang = (sy >= 0) ? longint'(HALF_TURN) + ang : ang - longint'(HALF_TURN);
				end
			end
			res.angle = ang[ANGLE_W-1:0];
			return res;
		endfunction

		function void note_input(logic [31:0] y, logic [31:0] x);
			owed_q.push_back(predict_angle(y, x));
		endfunction

		function void check_result(logic [ANGLE_W-1:0] angle, logic domain_error);
			angle_result_t want;
			if (owed_q.size() == 0) begin
				$display("%0t: unexpected result angle %h domain_error %b",
					$time, angle, domain_error);
				fails++;
				return;
			end
			want = owed_q.pop_front();
			if (angle !== want.angle) begin
				$display("%0t: angle mismatch: expected %h, got %h", $time, want.angle, angle);
				fails++;
			end
			if (domain_error !== want.domain_error) begin
				$display("%0t: domain_error mismatch: expected %b, got %b",
					$time, want.domain_error, domain_error);
				fails++;
			end
		endfunction

		function int outstanding();
			return owed_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;

	AngleScoreboard board;
	bit             steady = 1'b0;
	int             cycle_count = 0;

	fixed_point_atan2_table_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("fixed_point_atan2_table_search_tb failed");
			$finish;
		end
	end

	// Result side: check each accepted item, stall at random outside the steady stretch
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata[ANGLE_W-1:0], m_tuser[0]);
		m_tready <= steady || ($urandom_range(0, 99) >= 25);
	end

	task automatic send_item(input logic [31:0] y, input logic [31:0] x);
		while (!steady && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {x, y};
		do @(posedge clk); while (!s_tready);
		board.note_input(y, x);
	endtask

	task automatic make_random_item(output logic [31:0] y, output logic [31:0] x);
		int     pick;
		int     k;
		int     m;
		longint yy;
		longint xx;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			// land on a table entry, now and then one step off
			k  = $urandom_range(0, 127);
			m  = $urandom_range(1, 256);
			yy = longint'(TAN_ROM[k]) * m;
			if ($urandom_range(0, 3) == 0)
				yy = yy + int'($urandom_range(0, 2)) - 1;
			xx = 65536 * longint'(m);
		end else if (pick < 55) begin
			yy = $urandom_range(0, 1 << 20);
			xx = $urandom_range(0, 1 << 20);
		end else if (pick < 75) begin
			yy = $signed($urandom);
			xx = $signed($urandom);
		end else if (pick < 82) begin
			yy = ($urandom_range(0, 3) == 0) ? 0 : longint'($signed($urandom));
			xx = 0;
		end else if (pick < 88) begin
			yy = 0;
			xx = $signed($urandom);
		end else if (pick < 95) begin
			// straddle the quotient limit
			xx = $urandom_range(1, 65535);
			yy = longint'(QUOT_LIMIT) * xx + $urandom_range(0, 1);
		end else begin
			// quotient exactly halfway between two steps
			m  = $urandom_range(1, 8191);
			xx = 131072 * longint'(m);
			yy = (2 * longint'($urandom_range(0, 8191)) + 1) * m;
		end
		if ($urandom_range(0, 1))
			yy = -yy;
		if ($urandom_range(0, 1))
			xx = -xx;
		y = yy[31:0];
		x = xx[31:0];
	endtask

	initial begin
		logic [31:0] y;
		logic [31:0] x;
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_item(32'd0, 32'd0);
		send_item(32'd65536, 32'd0);
		send_item(-32'sd65536, 32'd0);
		send_item(32'h7FFF_FFFF, 32'd0);
		send_item(32'h8000_0000, 32'd0);
		send_item(32'd0, 32'd65536);
		send_item(32'd0, -32'sd65536);
		send_item(-32'sd1, -32'sd2147483647);
		send_item(32'd65536, 32'd65536);
		send_item(-32'sd65536, 32'd65536);
		send_item(32'd65536, -32'sd65536);
		send_item(-32'sd65536, -32'sd65536);
		send_item(32'h8000_0000, 32'h8000_0000);
		send_item(32'h7FFF_FFFF, 32'd1);
		send_item(32'h8000_0000, 32'd1);
		send_item(32'd32767, 32'd1);
		send_item(32'd32768, 32'd1);
		send_item(-32'sd32767, 32'd1);
		send_item(32'd1, 32'd131072);
		send_item(-32'sd3, 32'd131072);
		send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(32'd5340086, 32'd65536);
		send_item(-32'sd5340086, -32'sd65536);
		send_item(32'd1, 32'h8000_0000);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 400 && n < 600);
			make_random_item(y, x);
			send_item(y, x);
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;

		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.fails == 0 && board.outstanding() == 0)
			$display("fixed_point_atan2_table_search_tb passed");
		else
			$display("fixed_point_atan2_table_search_tb failed");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/atan_ts_pkg.sv
design/atan_ts_div.sv
design/atan_ts_rom.sv
design/fixed_point_atan2_table_search.sv
design/atan_ts_checker.sv
tb/sv/fixed_point_atan2_table_search_tb.sv
